[rtl/mwo_pkg.sv]
// Package for the multi-waveform oscillator: sizes, waveform codes,
// register map and the configuration struct shared by all rtl files.
// Depends on nothing.
`default_nettype none

package mwo_pkg;

  localparam int PHASE_BITS       = 22;
  localparam int SAMPLE_BITS      = 16;
  localparam int TABLE_VALUE_BITS = 8;
  localparam int TABLE_ADDR_BITS  = 7;
  localparam int TABLE_DEPTH      = 1 << TABLE_ADDR_BITS;
  localparam int NOISE_BITS       = 23;
  localparam int METAL_BITS       = 15;
  localparam int PULSE_BITS       = 12;
  localparam int PULSE_CMP_BITS   = 17;
  localparam int NOISE_CLK_BIT    = PHASE_BITS - 5;
  localparam int SCALE_SHIFT      = SAMPLE_BITS - TABLE_VALUE_BITS;

  // LFSR feedback masks (Galois, right shift)
  localparam logic [NOISE_BITS-1:0] NOISE_TAPS =
    NOISE_BITS'((1 << 22) | (1 << 17));
  localparam logic [NOISE_BITS-1:0] METAL_TAPS =
    NOISE_BITS'((1 << 14) | (1 << 8));
  localparam logic [NOISE_BITS-1:0] METAL_MASK = NOISE_BITS'((1 << METAL_BITS) - 1);

  localparam logic [PULSE_BITS-1:0] PULSE_FULL  = PULSE_BITS'(12'hfff);
  localparam logic [PULSE_BITS-1:0] PULSE_RESET = PULSE_BITS'(2048);

  // APB register map
  localparam int PADDR_BITS = 3;
  localparam logic REG_WAVEFORM    = 1'b0;
  localparam logic REG_PULSE_WIDTH = 1'b1;

  localparam logic CMD_SAMPLE      = 1'b0;
  localparam logic CMD_TABLE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    WAVE_NOISE    = 3'd0,
    WAVE_PULSE    = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_METALLIC = 3'd4,
    WAVE_SINE     = 3'd5
  } waveform_e;

  typedef struct packed {
    waveform_e             waveform;
    logic [PULSE_BITS-1:0] pulse_width;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/multi_waveform_oscillator.sv]
// Multi-waveform oscillator top level: input pipeline, sine table RAM,
// output register. Uses mwo_pkg, mwo_regs, mwo_sine_ram, mwo_wave_gen.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer.
//   A sample command gives one sample on the output channel
//   (out_valid_o / out_stall_i); a table write loads sine_table[table_index_i]
//   and gives nothing. Waveform and pulse width are set over the APB port
//   (0x0 waveform, 0x4 pulse width); the user must set them only while no
//   transfer is in flight, unchecked by the block. A sample passes the middle
//   stage, then the output register that drives out_valid_o. Throughput: one
//   transfer per cycle while in_stall_o is low; the sine RAM read port is
//   issued on every sample transfer and its registered data is used in the
//   next stage. A table write lands before a later read of the same entry.
//   Stall: when out_stall_i holds the output register, the middle stage
//   holds while full, and in_stall_o rises only when both are full.
//   Reset: pipeline empty, waveform pulse, pulse width 2048, noise LFSR all
//   ones; sine table contents are undefined until written.
`default_nettype none

module multi_waveform_oscillator
  import mwo_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB config
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [PADDR_BITS-1:0]       paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [PHASE_BITS-1:0]       phase_i,
  input  wire logic [PHASE_BITS-1:0]       previous_phase_i,
  input  wire logic [TABLE_ADDR_BITS-1:0]  table_index_i,
  input  wire logic [TABLE_VALUE_BITS-1:0] table_value_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [SAMPLE_BITS-1:0]      sample_o
);

  cfg_t                        cfg;
  logic                        in_xfer;
  logic                        smp_xfer;
  logic                        wr_xfer;
  logic [SAMPLE_BITS-1:0]      gen_sample;
  logic [TABLE_VALUE_BITS-1:0] ram_rdata;

  // middle stage: waits on the RAM read
  logic                        mid_valid_q, mid_valid_d;
  logic                        mid_sine_q;
  logic [SAMPLE_BITS-1:0]      mid_sample_q;
  logic                        mid_adv;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]      out_sample_q;
  logic                        out_load;

  mwo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the output register frees when empty or when its sample is taken
  assign out_load   = !out_valid_q || !out_stall_i;
  assign mid_adv    = mid_valid_q && out_load;
  assign in_stall_o = mid_valid_q && !out_load;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign smp_xfer = in_xfer && (command_i == CMD_SAMPLE);
  assign wr_xfer  = in_xfer && (command_i == CMD_TABLE_WRITE);

  mwo_wave_gen u_wave_gen (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .step_i           (smp_xfer),
    .phase_i          (phase_i),
    .previous_phase_i (previous_phase_i),
    .sample_o         (gen_sample)
  );

  // read only on a sample transfer so the data holds while the stage waits
  mwo_sine_ram u_sine_ram (
    .clk_i   (clk_i),
    .we_i    (wr_xfer),
    .waddr_i (table_index_i),
    .wdata_i (table_value_i),
    .re_i    (smp_xfer),
    .raddr_i (phase_i[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .rdata_o (ram_rdata)
  );

  // middle stage takes a new sample whenever it is empty or advancing
  always_comb begin
    mid_valid_d = mid_valid_q;
    if (!mid_valid_q || mid_adv) begin
      mid_valid_d = smp_xfer;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_xfer) begin
      mid_sine_q   <= (cfg.waveform == WAVE_SINE);
      mid_sample_q <= gen_sample;
    end
  end

  // output register: hold while stalled, else load from the middle stage
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = mid_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_adv) begin
      // scale the table value up to the sample width
      out_sample_q <= mid_sine_q ? {ram_rdata, {SCALE_SHIFT{1'b0}}} : mid_sample_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;

endmodule

`default_nettype wire

[rtl/mwo_sine_ram.sv]
// Sine table: 128 x 8 synchronous RAM, one write port and one read port
// with registered read data. Uses mwo_pkg.
`default_nettype none

module mwo_sine_ram
  import mwo_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [TABLE_ADDR_BITS-1:0]  waddr_i,
  input  wire logic [TABLE_VALUE_BITS-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [TABLE_ADDR_BITS-1:0]  raddr_i,
  output logic      [TABLE_VALUE_BITS-1:0] rdata_o
);

  logic [TABLE_VALUE_BITS-1:0] mem [TABLE_DEPTH];
  logic [TABLE_VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data unless a new read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/mwo_regs.sv]
// APB configuration registers: waveform select and pulse width.
// Uses mwo_pkg.
`default_nettype none

module mwo_regs
  import mwo_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_WAVEFORM:    cfg_d.waveform    = waveform_e'(pwdata[2:0]);
        REG_PULSE_WIDTH: cfg_d.pulse_width = pwdata[PULSE_BITS-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform    <= WAVE_PULSE;
      cfg_q.pulse_width <= PULSE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WAVEFORM:    prdata = {29'd0, cfg_q.waveform};
      REG_PULSE_WIDTH: prdata = {20'd0, cfg_q.pulse_width};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/mwo_wave_gen.sv]
// Waveform logic for the accept cycle: noise LFSR register, pulse, saw and
// triangle samples. Sine comes from the table's registered read data. Uses mwo_pkg.
`default_nettype none

module mwo_wave_gen
  import mwo_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   step_i,
  input  wire logic [PHASE_BITS-1:0]  phase_i,
  input  wire logic [PHASE_BITS-1:0]  previous_phase_i,
  output logic      [SAMPLE_BITS-1:0] sample_o
);

  logic [NOISE_BITS-1:0]     noise_q, noise_d;
  logic [NOISE_BITS-1:0]     noise_taps;
  logic                      noise_tick;
  logic [PULSE_BITS:0]       threshold;
  logic [PULSE_CMP_BITS-1:0] pulse_ph;
  logic [PHASE_BITS-1:0]     folded;

  assign noise_tick = phase_i[NOISE_CLK_BIT] != previous_phase_i[NOISE_CLK_BIT];
  assign noise_taps = noise_q[0] ? ((cfg_i.waveform == WAVE_METALLIC) ? METAL_TAPS
                                                                     : NOISE_TAPS)
                                 : '0;

  // advance the LFSR only for a sample transfer of a noise waveform whose phase crosses the noise clock bit
  always_comb begin
    noise_d = noise_q;
    if (step_i && noise_tick) begin
      case (cfg_i.waveform)
        WAVE_NOISE:    noise_d = (noise_q >> 1) ^ noise_taps;
        WAVE_METALLIC: noise_d = ((noise_q >> 1) ^ noise_taps) & METAL_MASK;
        default:       noise_d = noise_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '1;
    end else begin
      noise_q <= noise_d;
    end
  end

  assign threshold = (cfg_i.pulse_width == PULSE_FULL) ? (PULSE_BITS+1)'(1 << PULSE_BITS)
                                                       : {1'b0, cfg_i.pulse_width};
  assign pulse_ph  = phase_i[PHASE_BITS-1 -: PULSE_CMP_BITS];
  assign folded    = phase_i[PHASE_BITS-1] ? ~phase_i : phase_i;

  always_comb begin
    case (cfg_i.waveform)
      WAVE_NOISE,
      WAVE_METALLIC: sample_o = noise_d[SAMPLE_BITS-1:0];
      WAVE_PULSE:    sample_o = (pulse_ph >= {threshold, 4'd0}) ? '1 : '0;
      WAVE_TRIANGLE: sample_o = folded[PHASE_BITS-3 -: SAMPLE_BITS];
      WAVE_SAW:      sample_o = phase_i[PHASE_BITS-2 -: SAMPLE_BITS];
      default:       sample_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[tb/mwo_sample_checker.sv]
`timescale 1ns / 100ps
// Sample checker for the multi-waveform oscillator: watches the APB port and
// both channels, predicts every sample and compares it. Depends on mwo_pkg.
module mwo_sample_checker
  import mwo_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [PADDR_BITS-1:0]       paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        command_i,
  input  logic [PHASE_BITS-1:0]       phase_i,
  input  logic [PHASE_BITS-1:0]       previous_phase_i,
  input  logic [TABLE_ADDR_BITS-1:0]  table_index_i,
  input  logic [TABLE_VALUE_BITS-1:0] table_value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  logic [2:0]                  wave_sel;
  logic [PULSE_BITS-1:0]       pulse_thresh;
  logic [NOISE_BITS-1:0]       noise_lfsr;
  logic [TABLE_VALUE_BITS-1:0] sine_mem [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0]      expected_samples [$];
  logic [SAMPLE_BITS-1:0]      want;
  int fail_count    = 0;
  int pending_count = 0;
  int checked_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] sample check: %s", $time, what);
    fail_count++;
  endtask

  // Advance the noise source when needed and form the sample of one transfer.
  function automatic logic [SAMPLE_BITS-1:0] next_sample(
    input logic [PHASE_BITS-1:0] ph,
    input logic [PHASE_BITS-1:0] prev
  );
    logic                      noise_tick;
    logic [PHASE_BITS-1:0]     folded;
    logic [PULSE_CMP_BITS-1:0] thresh;
    logic [SAMPLE_BITS-1:0]    s;
    noise_tick = ph[NOISE_CLK_BIT] != prev[NOISE_CLK_BIT];
    s = '0;
    case (wave_sel)
      WAVE_NOISE: begin
        if (noise_tick)
          noise_lfsr = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? NOISE_TAPS : '0);
        s = noise_lfsr[SAMPLE_BITS-1:0];
      end
      WAVE_METALLIC: begin
        if (noise_tick)
          noise_lfsr = ((noise_lfsr >> 1) ^ (noise_lfsr[0] ? METAL_TAPS : '0)) & METAL_MASK;
        s = noise_lfsr[SAMPLE_BITS-1:0];
      end
      WAVE_PULSE: begin
        thresh = {1'b0, pulse_thresh, 4'b0000};
        if (pulse_thresh == PULSE_FULL)
          thresh = {1'b1, {(PULSE_CMP_BITS-1){1'b0}}};
        if (ph[PHASE_BITS-1 -: PULSE_CMP_BITS] >= thresh)
          s = '1;
      end
      WAVE_TRIANGLE: begin
        folded = ph[PHASE_BITS-1] ? ~ph : ph;
        s = folded[PHASE_BITS-3 -: SAMPLE_BITS];
      end
      WAVE_SAW: s = ph[PHASE_BITS-2 -: SAMPLE_BITS];
      WAVE_SINE: s = {sine_mem[ph[PHASE_BITS-1 -: TABLE_ADDR_BITS]], {SCALE_SHIFT{1'b0}}};
      default: s = '0;
    endcase
    return s;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      wave_sel     = WAVE_PULSE;
      pulse_thresh = PULSE_RESET;
      noise_lfsr   = '1;
      expected_samples.delete();
      pending_count <= 0;
    end else begin
      // retire first, so a stray sample never takes a fresh expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %h with nothing expected", sample_i));
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (sample_i !== want)
            report_mismatch($sformatf("sample %h, expected %h", sample_i, want));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_WAVEFORM)
          wave_sel = pwdata_i[2:0];
        else
          pulse_thresh = pwdata_i[PULSE_BITS-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_TABLE_WRITE)
          sine_mem[table_index_i] = table_value_i;
        else
          expected_samples.push_back(next_sample(phase_i, previous_phase_i));
      end
      pending_count <= expected_samples.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top of the multi-waveform oscillator testbench: clock, reset, stimulus,
// register settings and verdict. Depends on mwo_pkg and mwo_sample_checker.
module testbench;
  import mwo_pkg::*;

  // Waveform codes with no waveform behind them; the block answers zero.
  localparam logic [2:0] WAVE_SILENT_LO = 3'd6;
  localparam logic [2:0] WAVE_SILENT_HI = 3'd7;

  localparam int ITEM_TARGET   = 750;
  localparam int ROUND_ITEMS   = 45;
  localparam int QUIET_TAIL    = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int RUN_LIMIT_NS  = 1_000_000;

  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        psel             = 1'b0;
  logic                        penable          = 1'b0;
  logic                        pwrite           = 1'b0;
  logic [PADDR_BITS-1:0]       paddr            = '0;
  logic [31:0]                 pwdata           = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid_i       = 1'b0;
  logic                        in_stall_o;
  logic                        command_i        = CMD_SAMPLE;
  logic [PHASE_BITS-1:0]       phase_i          = '0;
  logic [PHASE_BITS-1:0]       previous_phase_i = '0;
  logic [TABLE_ADDR_BITS-1:0]  table_index_i    = '0;
  logic [TABLE_VALUE_BITS-1:0] table_value_i    = '0;
  logic                        out_valid_o;
  logic                        out_stall_i      = 1'b0;
  logic [SAMPLE_BITS-1:0]      sample_o;

  int fail_count;
  int pending;
  int checked;

  // Idling switches; both drop for the quiet tail of the run.
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int stall_left     = 0;

  int items_sent  = 0;
  int table_loads = 0;
  int settings    = 0;

  always #2 clk_i = ~clk_i;

  multi_waveform_oscillator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .phase_i          (phase_i),
    .previous_phase_i (previous_phase_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_o         (sample_o)
  );

  mwo_sample_checker sample_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .command_i        (command_i),
    .phase_i          (phase_i),
    .previous_phase_i (previous_phase_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_i         (sample_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Receiver: start stall bursts at random while idling is on.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Present one transfer, maybe after a gap, and hold it until it is taken.
  // Called at a rising edge; returns at the edge that accepts the transfer.
  task automatic send_item(
    input logic                        cmd,
    input logic [PHASE_BITS-1:0]       ph,
    input logic [PHASE_BITS-1:0]       prev,
    input logic [TABLE_ADDR_BITS-1:0]  idx,
    input logic [TABLE_VALUE_BITS-1:0] val
  );
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    phase_i          <= ph;
    previous_phase_i <= prev;
    table_index_i    <= idx;
    table_value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (cmd == CMD_TABLE_WRITE)
      table_loads++;
  endtask

  // Unused fields of a transfer carry random bits.
  task automatic sample_item(input logic [PHASE_BITS-1:0] ph, input logic [PHASE_BITS-1:0] prev);
    send_item(CMD_SAMPLE, ph, prev, TABLE_ADDR_BITS'($urandom), TABLE_VALUE_BITS'($urandom));
  endtask

  task automatic table_item(input logic [TABLE_ADDR_BITS-1:0] idx,
                            input logic [TABLE_VALUE_BITS-1:0] val);
    send_item(CMD_TABLE_WRITE, PHASE_BITS'($urandom), PHASE_BITS'($urandom), idx, val);
  endtask

  // Drop valid and hold off until every expected sample is in, then give a
  // trailing table write time to land as well.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands at the access edge.
  // Select stays up so a second write can follow straight away.
  task automatic apb_write(input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Registers change only with the block idle, so drain first.
  task automatic configure(input logic [2:0] wave, input logic [PULSE_BITS-1:0] width);
    wait_until_drained();
    apb_write(REG_WAVEFORM, {29'b0, wave});
    apb_write(REG_PULSE_WIDTH, {{(32-PULSE_BITS){1'b0}}, width});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  // One round of random transfers under the current setting. Most items
  // follow a running phase accumulator with a fixed step, so noise clocks
  // the way it would in use; the rest are unrelated phase pairs and loads.
  task automatic random_round(input int count);
    logic [PHASE_BITS-1:0] acc;
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] prev;
    int                    pick;
    acc = PHASE_BITS'($urandom);
    case ($urandom_range(0, 2))
      0:       step = PHASE_BITS'($urandom_range(1, 2047));
      1:       step = PHASE_BITS'($urandom_range(2048, 1 << 18));
      default: step = PHASE_BITS'($urandom);
    endcase
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        table_item(TABLE_ADDR_BITS'($urandom), TABLE_VALUE_BITS'($urandom));
      end else if (pick == 1) begin
        sample_item(PHASE_BITS'($urandom), PHASE_BITS'($urandom));
      end else begin
        prev = acc;
        acc  = acc + step;
        sample_item(acc, prev);
      end
    end
  endtask

  initial begin
    logic [2:0]            wave;
    logic [PULSE_BITS-1:0] width;
    int                    round_no;
    bit                    tail;

    // hold reset, then release it at an edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: load a few table entries, including both ends of the table.
    table_item(7'd0, 8'hff);
    table_item(7'd127, 8'h80);
    table_item(7'h55, 8'h01);
    table_item(7'h2a, 8'h7e);

    // Pulse at reset width: phase ends and both sides of the threshold.
    sample_item(22'h000000, 22'h000000);
    sample_item(22'h3fffff, 22'h3fffff);
    sample_item(22'h100000, 22'h0fffff);
    sample_item(22'h0fffff, 22'h100000);

    // Triangle around the fold, saw at both ends.
    configure(WAVE_TRIANGLE, PULSE_RESET);
    sample_item(22'h1fffff, 22'h000000);
    sample_item(22'h200000, 22'h1fffff);
    sample_item(22'h3fffff, 22'h200000);
    configure(WAVE_SAW, PULSE_BITS'($urandom));
    sample_item(22'h000000, 22'h3fffff);
    sample_item(22'h3fffff, 22'h000000);

    // Sine from the first, last and a middle entry.
    configure(WAVE_SINE, PULSE_BITS'($urandom));
    sample_item(22'h000000, 22'h000000);
    sample_item(22'h3fffff, 22'h000000);
    sample_item({7'h55, 15'h1234}, 22'h000000);

    // Noise: step, no step, a table load that must leave the noise alone.
    configure(WAVE_NOISE, PULSE_BITS'($urandom));
    sample_item(22'h020000, 22'h000000);
    sample_item(22'h020000, 22'h020000);
    table_item(7'h2a, 8'h00);
    sample_item(22'h000000, 22'h3fffff);

    // Switch to metallic and back: the normal source resumes from 15 bits.
    configure(WAVE_METALLIC, PULSE_BITS'($urandom));
    sample_item(22'h020000, 22'h000000);
    sample_item(22'h000000, 22'h020000);
    configure(WAVE_NOISE, PULSE_BITS'($urandom));
    sample_item(22'h020000, 22'h000000);

    // Undefined codes answer zero.
    configure(WAVE_SILENT_LO, PULSE_BITS'($urandom));
    sample_item(22'h3fffff, 22'h000000);
    configure(WAVE_SILENT_HI, PULSE_BITS'($urandom));
    sample_item(22'h3fffff, 22'h000000);

    // Fill the whole sine table so no later read meets an empty entry.
    for (int i = 0; i < TABLE_DEPTH; i++)
      table_item(i[TABLE_ADDR_BITS-1:0], TABLE_VALUE_BITS'($urandom));

    // Random rounds: planned settings first, then random ones. Every fourth
    // round runs without idling; the tail of the run runs without it too.
    round_no = 0;
    while (items_sent < ITEM_TARGET) begin
      tail           = (ITEM_TARGET - items_sent) <= QUIET_TAIL;
      sender_idles   = !tail && (round_no % 4 != 3);
      receiver_idles = sender_idles;
      width          = PULSE_BITS'($urandom);
      case (round_no)
        0:  wave = WAVE_NOISE;
        1:  wave = WAVE_METALLIC;
        2:  wave = WAVE_NOISE;
        3: begin
          wave  = WAVE_PULSE;
          width = '0;
        end
        4: begin
          wave  = WAVE_PULSE;
          width = PULSE_FULL;
        end
        5: begin
          wave  = WAVE_PULSE;
          width = PULSE_FULL - 1'b1;
        end
        6:  wave = WAVE_TRIANGLE;
        7:  wave = WAVE_SAW;
        8:  wave = WAVE_SINE;
        9:  wave = WAVE_SILENT_LO;
        10: wave = WAVE_SILENT_HI;
        11: wave = WAVE_METALLIC;
        12: begin
          wave  = WAVE_PULSE;
          width = 12'd1;
        end
        13: wave = WAVE_SINE;
        default: wave = 3'($urandom_range(0, 7));
      endcase
      configure(wave, width);
      random_round(tail ? ITEM_TARGET - items_sent : ROUND_ITEMS);
      round_no++;
    end

    // let everything in flight come out, then give the verdict
    wait_until_drained();
    $display("covered %0d transfers (%0d sine table loads), %0d samples checked",
             items_sent, table_loads, checked);
    $display("over %0d register settings: all eight waveform codes, pulse width 0 to full",
             settings);
    if (fail_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Watchdog: a hung handshake or a sample that never comes ends here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[multi_waveform_oscillator.f]
rtl/mwo_pkg.sv
rtl/mwo_sine_ram.sv
rtl/mwo_regs.sv
rtl/mwo_wave_gen.sv
rtl/multi_waveform_oscillator.sv
tb/mwo_sample_checker.sv
tb/testbench.sv
